/* rtl/masked_byte_pattern_scan_core_defines.svh */
// assertion macros used by the checker file
`ifndef MASKED_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define MBPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mbps_pkg.sv */
// types, constants and helpers of the masked byte pattern scanner
package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int PAT_BYTES   = 16;
    localparam int LEN_W       = 5;
    localparam int ADDR_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_MASK_LOW       = 3'd2,
        CFG_MASK_HIGH      = 3'd3,
        CFG_PATTERN_LENGTH = 3'd4,
        CFG_REGION_START   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       readable;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_out_item;

    typedef logic [7:0] t_byte;

    // length zero acts as one, anything above the window depth as the depth
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = len;
        if (n == '0) begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(MAX_PATTERN)) begin
            n = LEN_W'(MAX_PATTERN);
        end
        return n;
    endfunction

endpackage

/* rtl/masked_byte_pattern_scan_core.sv */
// masked byte pattern scanner, top level
// Bytes of a region enter one per item in address order; the core keeps the latest
// sixteen readable bytes and compares them against the configured pattern, using
// only the byte positions whose mask byte is nonzero. It returns one result per
// region: the start address of the first match, reported on the byte that
// completes it, or found=0 with address 0 on the last byte if nothing matched.
// An unreadable byte empties the window but still advances the address. The core
// takes one item per clock unless it stalls; a result passes through the input
// register and then the two-entry output queue before it leaves. The input
// side only stalls when both queue entries hold results not yet taken.
// The user must write configuration registers only while the core is idle; the
// core does not enforce it. Writing region_start also reloads the running address.
module masked_byte_pattern_scan_core import mbps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [CFG_DATA_W-1:0] r_mask_lo;
    logic [CFG_DATA_W-1:0] r_mask_hi;
    logic [LEN_W-1:0]      r_len;
    logic [ADDR_W-1:0]     r_region;

    logic              r_s1_valid;
    t_in_item          r_s1_item;
    logic [ADDR_W-1:0] r_addr;
    logic              r_seen;
    logic [ADDR_W-1:0] n_addr;
    logic              n_seen;

    logic              room;
    logic              fire;
    logic              in_acc;
    logic              cfg_wr;
    logic              win_hit;
    logic              hit;
    logic              emit;
    logic [LEN_W-1:0]  len;
    t_out_item         res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign len         = clamp_len(r_len);

    assign fire       = r_s1_valid && room;
    assign o_in_stall = r_s1_valid && !room;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_mask_lo <= '0;
            r_mask_hi <= '0;
            r_len     <= LEN_W'(1);
            r_region  <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:    r_pat_lo  <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_hi  <= i_cfg_data;
                CFG_MASK_LOW:       r_mask_lo <= i_cfg_data;
                CFG_MASK_HIGH:      r_mask_hi <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_len     <= i_cfg_data[LEN_W-1:0];
                CFG_REGION_START:   r_region  <= i_cfg_data[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in;
        end
    end

    mbps_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_s1_item),
        .i_len     (len),
        .i_pattern ({r_pat_hi, r_pat_lo}),
        .i_mask    ({r_mask_hi, r_mask_lo}),
        .o_hit     (win_hit)
    );

    // one result per region: first match, or not found on the last byte
    assign hit  = win_hit && !r_seen;
    assign emit = hit || (r_s1_item.last && !r_seen);

    always_comb begin
        res.found         = hit;
        res.match_address = hit ? (r_addr - ADDR_W'(len - LEN_W'(1))) : '0;
    end

    always_comb begin
        n_seen = r_s1_item.last ? 1'b0 : (r_seen || hit);
        n_addr = r_s1_item.last ? r_region : (r_addr + ADDR_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_addr <= '0;
        end else if (cfg_wr && (i_cfg_index == CFG_REGION_START)) begin
            r_addr <= i_cfg_data[ADDR_W-1:0];
        end else if (fire) begin
            r_seen <= n_seen;
            r_addr <= n_addr;
        end
    end

    mbps_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && emit),
        .i_item  (res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out)
    );

endmodule

/* rtl/mbps_window.sv */
// sliding byte window with fill count and masked pattern compare
module mbps_window import mbps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  t_in_item              i_item,
    input  logic [LEN_W-1:0]      i_len,
    input  logic [8*PAT_BYTES-1:0] i_pattern,
    input  logic [8*PAT_BYTES-1:0] i_mask,
    output logic                  o_hit
);

    t_byte             r_win [MAX_PATTERN];
    t_byte             n_win [MAX_PATTERN];
    logic [LEN_W-1:0]  r_fill;
    logic [LEN_W-1:0]  n_fill;
    logic [LEN_W-1:0]  fill_step;
    logic [3:0]        len_m1;
    logic              cmp_ok;

    // window after this item, newest byte at position zero
    always_comb begin
        n_win[0] = i_item.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    always_comb begin
        if (!i_item.readable) begin
            fill_step = '0;
        end else if (r_fill == LEN_W'(MAX_PATTERN)) begin
            fill_step = r_fill;
        end else begin
            fill_step = r_fill + LEN_W'(1);
        end
    end

    assign len_m1 = 4'(i_len - LEN_W'(1));

    // window position k faces pattern byte len-1-k
    always_comb begin
        logic [3:0] j;
        j      = '0;
        cmp_ok = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            j = len_m1 - 4'(k);
            if (LEN_W'(k) < i_len) begin
                if ((i_mask[8*j +: 8] != 8'd0) && (n_win[k] != i_pattern[8*j +: 8])) begin
                    cmp_ok = 1'b0;
                end
            end
        end
    end

    assign o_hit = i_item.readable && (fill_step >= i_len) && cmp_ok;

    always_comb begin
        n_fill = i_item.last ? '0 : fill_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_fire) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_item.readable) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

endmodule

/* rtl/mbps_outq.sv */
// two-entry result queue between the scan stage and the output port
module mbps_outq import mbps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_out_item  r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_room  = !r_cnt[1];
    assign o_item  = r_q[r_rd];
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_item;
        end
    end

endmodule

/* rtl/mbps_checker.sv */
// port-level checks for the masked byte pattern scanner and their binding
`include "masked_byte_pattern_scan_core_defines.svh"

module mbps_checker import mbps_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    `MBPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid, "result item dropped while stalled")

    `MBPS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall,
        $stable(o_out), "stalled result item changed")

    `MBPS_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out.found,
        o_out.match_address == '0, "not-found item carries an address")

    `MBPS_ASSERT_SAME(a_out_cause, i_clk, i_rst_n, $rose(o_out_valid),
        $past(in_acc, 2), "result item without an input item two cycles back")

endmodule

bind masked_byte_pattern_scan_core mbps_checker u_mbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

/* bench/tb_masked_byte_pattern_scan_core.sv */
`timescale 1ns / 1ps
// self-checking bench for the masked byte pattern scanner: byte streams, scoreboard, idling
module tb_masked_byte_pattern_scan_core;
    import mbps_pkg::*;

    localparam int unsigned PHASE_COUNT     = 12;
    localparam int unsigned ITEMS_PER_PHASE = 152;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned QUIET_LIMIT     = 20000;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned MAX_REGION      = 128;

    // indexes past the last register, writes to them change nothing
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_B = 3'd7;

    class scan_scoreboard;
        t_out_item         due_reports[$];
        int unsigned       mismatches;
        logic [63:0]       pat_lo, pat_hi, mask_lo, mask_hi;
        logic [LEN_W-1:0]  pat_len;
        logic [ADDR_W-1:0] region_base, next_addr;
        t_byte             window[MAX_PATTERN];
        int unsigned       fill;
        bit                matched;

        function new();
            mismatches = 0;
            pat_lo = '0;
            pat_hi = '0;
            mask_lo = '0;
            mask_hi = '0;
            pat_len = LEN_W'(1);
            region_base = '0;
            restart_region();
        endfunction

        function void restart_region();
            foreach (window[k]) window[k] = '0;
            fill = 0;
            matched = 1'b0;
            next_addr = region_base;
        endfunction

        function int unsigned active_length();
            int unsigned n;
            n = pat_len;
            if (n == 0) begin
                n = 1;
            end
            if (n > MAX_PATTERN) begin
                n = MAX_PATTERN;
            end
            return n;
        endfunction

        function t_byte lane(input logic [63:0] lo, input logic [63:0] hi,
                             input int unsigned j);
            if (j < 8) begin
                return lo[8*j +: 8];
            end
            return hi[8*(j-8) +: 8];
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PATTERN_LOW:    pat_lo = value;
                CFG_PATTERN_HIGH:   pat_hi = value;
                CFG_MASK_LOW:       mask_lo = value;
                CFG_MASK_HIGH:      mask_hi = value;
                CFG_PATTERN_LENGTH: pat_len = value[LEN_W-1:0];
                CFG_REGION_START: begin
                    region_base = value[ADDR_W-1:0];
                    next_addr = region_base;
                end
                default: ;
            endcase
        endfunction

        function void take_byte(input t_in_item it);
            logic [ADDR_W-1:0] here;
            int unsigned       n;
            bit                hit;
            t_out_item         r;
            here = next_addr;
            n = active_length();
            if (it.readable) begin
                for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
                window[0] = it.data_byte;
                if (fill < MAX_PATTERN) begin
                    fill++;
                end
            end else begin
                foreach (window[k]) window[k] = '0;
                fill = 0;
            end
            next_addr = here + 1'b1;
            if (!matched && it.readable && fill >= n) begin
                hit = 1'b1;
                // window[0] is the newest byte, so pattern byte 0 sits deepest
                for (int j = 0; j < n; j++) begin
                    if (lane(mask_lo, mask_hi, j) != 0 &&
                        window[n-1-j] != lane(pat_lo, pat_hi, j)) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    matched = 1'b1;
                    r.found = 1'b1;
                    r.match_address = here - ADDR_W'(n - 1);
                    due_reports.push_back(r);
                end
            end
            if (it.last) begin
                if (!matched) begin
                    r.found = 1'b0;
                    r.match_address = '0;
                    due_reports.push_back(r);
                end
                restart_region();
            end
        endfunction

        function void check_report(input t_out_item got);
            t_out_item want;
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: result with none expected: found=%0b addr=%h",
                             $realtime, got.found, got.match_address);
                end
            end else begin
                want = due_reports.pop_front();
                if (got.found !== want.found || got.match_address !== want.match_address) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: mismatch: expected found=%0b addr=%h, got found=%0b addr=%h",
                                 $realtime, want.found, want.match_address,
                                 got.found, got.match_address);
                    end
                end
            end
        endfunction

        function int unsigned pending();
            return due_reports.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    scan_scoreboard sb;
    t_in_item       byte_stream[$];
    t_byte          cur_pattern[MAX_PATTERN];
    t_byte          cur_mask[MAX_PATTERN];
    int unsigned    cur_len;
    bit             hold_req = 1'b0;
    bit             no_idle = 1'b0;

    wire in_taken  = i_in_valid && !o_in_stall;
    wire out_taken = o_out_valid && !i_out_stall;
    wire cfg_taken = i_cfg_valid && o_cfg_ready;

    masked_byte_pattern_scan_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_taken) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (in_taken) begin
                sb.take_byte(i_in);
            end
            if (out_taken) begin
                sb.check_report(o_out);
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item byte_item(input t_byte d, input logic rd, input logic lst);
        t_in_item it;
        it.data_byte = d;
        it.readable = rd;
        it.last = lst;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int unsigned g;
        g = no_idle ? 0 : pick_gap();
        if (g > 0) begin
            i_in_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait out every expected result, then let items with no result leave the pipe
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input int unsigned p);
        logic [63:0]       pl, ph, ml, mh, lw, sw;
        logic [LEN_W-1:0]  len_raw;
        logic [ADDR_W-1:0] start;
        int unsigned       mmode;
        bit                coarse;
        coarse = ($urandom_range(0, 3) == 0);
        mmode = (p == 0) ? 1 : (p == 4) ? 0 : $urandom_range(0, 3);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            cur_pattern[k] = coarse ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : t_byte'($urandom);
            case (mmode)
                0: cur_mask[k] = 8'h00;
                1: cur_mask[k] = 8'hFF;
                2: cur_mask[k] = $urandom_range(0, 1) ? t_byte'($urandom_range(1, 255)) : 8'h00;
                default: cur_mask[k] = ($urandom_range(0, 5) == 0) ? 8'h00
                                                                   : t_byte'($urandom_range(1, 255));
            endcase
        end
        for (int k = 0; k < 8; k++) begin
            pl[8*k +: 8] = cur_pattern[k];
            ph[8*k +: 8] = cur_pattern[k+8];
            ml[8*k +: 8] = cur_mask[k];
            mh[8*k +: 8] = cur_mask[k+8];
        end
        case (p)
            0, 4: len_raw = LEN_W'(16);
            1: len_raw = LEN_W'(0);
            2: len_raw = LEN_W'(31);
            3: len_raw = LEN_W'(17);
            5: len_raw = LEN_W'(1);
            default: len_raw = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 31))
                                                           : LEN_W'($urandom_range(1, 8));
        endcase
        case (p)
            1: start = 32'hFFFF_FFF0;
            5: start = 32'hFFFF_FFFF;
            7: start = 32'h0000_0000;
            default: start = $urandom;
        endcase
        // junk above the register width must be dropped
        lw = {$urandom, $urandom};
        lw[LEN_W-1:0] = len_raw;
        sw = {$urandom, start};
        cfg_write(CFG_PATTERN_LOW, pl);
        cfg_write(CFG_PATTERN_HIGH, ph);
        cfg_write(CFG_MASK_LOW, ml);
        cfg_write(CFG_MASK_HIGH, mh);
        cfg_write(CFG_PATTERN_LENGTH, lw);
        cfg_write(CFG_REGION_START, sw);
        if (p == 9) begin
            cfg_write(UNUSED_REG_A, {$urandom, $urandom});
            cfg_write(UNUSED_REG_B, {$urandom, $urandom});
        end
        cur_len = sb.active_length();
    endtask

    // one region: random content, usually with the pattern planted somewhere
    task automatic build_region();
        int unsigned n, at, j, mode;
        t_byte       body[MAX_REGION];
        bit          ok[MAX_REGION];
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
        mode = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            body[k] = (mode == 0) ? cur_pattern[$urandom_range(0, cur_len - 1)] : t_byte'($urandom);
            ok[k] = ($urandom_range(0, 24) != 0);
        end
        if ($urandom_range(0, 9) < 7 && cur_len <= n) begin
            at = $urandom_range(0, n - cur_len);
            for (int k = 0; k < cur_len; k++) begin
                body[at+k] = (cur_mask[k] != 0) ? cur_pattern[k] : t_byte'($urandom);
                ok[at+k] = 1'b1;
            end
            // near misses: one byte flipped, or one byte made unreadable
            j = at + $urandom_range(0, cur_len - 1);
            case ($urandom_range(0, 7))
                0: body[j] = ~body[j];
                1: ok[j] = 1'b0;
                default: ;
            endcase
        end
        for (int k = 0; k < n; k++) begin
            byte_stream.push_back(byte_item(body[k], ok[k], k == n - 1));
        end
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                stall_left = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall = 1'b1;
            end else if (!no_idle && $urandom_range(0, 2) == 0) begin
                stall_left = pick_gap();
                i_out_stall = (stall_left > 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_taken || out_taken || cfg_taken) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_masked_byte_pattern_scan_core: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_in_item seq[$];
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: length one, empty mask, so any readable byte matches
        seq.push_back(byte_item(8'h00, 1'b1, 1'b0));
        seq.push_back(byte_item(8'hFF, 1'b1, 1'b0));
        seq.push_back(byte_item(8'h5A, 1'b0, 1'b1));
        seq.push_back(byte_item(8'hFF, 1'b0, 1'b1));
        seq.push_back(byte_item(8'hA5, 1'b0, 1'b0));
        seq.push_back(byte_item(8'h3C, 1'b1, 1'b1));
        foreach (seq[k]) send_item(seq[k]);
        i_in_valid = 1'b0;
        drain();

        // four-byte pattern 00 ff 80 7f, second byte don't care, start just below wrap
        cfg_write(CFG_PATTERN_LOW, 64'hA5C3_1E69_7F80_FF00);
        cfg_write(CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(CFG_MASK_LOW, 64'h1234_5678_80FF_0001);
        cfg_write(CFG_MASK_HIGH, 64'h8000_0000_0000_0001);
        cfg_write(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE4);
        cfg_write(CFG_REGION_START, 64'hDEAD_BEEF_FFFF_FFFE);
        seq.delete();
        seq.push_back(byte_item(8'h00, 1'b1, 1'b0));
        seq.push_back(byte_item(8'h55, 1'b1, 1'b0));
        seq.push_back(byte_item(8'h80, 1'b1, 1'b0));
        seq.push_back(byte_item(8'h11, 1'b0, 1'b0));
        seq.push_back(byte_item(8'h00, 1'b1, 1'b0));
        seq.push_back(byte_item(8'hAA, 1'b1, 1'b0));
        seq.push_back(byte_item(8'h80, 1'b1, 1'b0));
        seq.push_back(byte_item(8'h7F, 1'b1, 1'b1));
        seq.push_back(byte_item(8'h00, 1'b1, 1'b0));
        seq.push_back(byte_item(8'hFF, 1'b1, 1'b0));
        seq.push_back(byte_item(8'h80, 1'b1, 1'b0));
        seq.push_back(byte_item(8'h7E, 1'b1, 1'b1));
        for (int r = 0; r < 2; r++) begin
            seq.push_back(byte_item(8'h00, 1'b1, 1'b0));
            seq.push_back(byte_item(8'hFF, 1'b1, 1'b0));
            seq.push_back(byte_item(8'h80, 1'b1, 1'b0));
            seq.push_back(byte_item(8'h7F, 1'b1, r == 1));
        end
        foreach (seq[k]) send_item(seq[k]);
        i_in_valid = 1'b0;
        drain();

        // regions carry over phase boundaries, so settings also change mid-region
        for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
            apply_settings(p);
            no_idle = (p == 2 || p == 9);
            if (p == 6) begin
                hold_req = 1'b1;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (byte_stream.size() == 0) begin
                    build_region();
                end
                send_item(byte_stream.pop_front());
            end
            i_in_valid = 1'b0;
            no_idle = 1'b0;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_masked_byte_pattern_scan_core: PASS");
        end else begin
            $display("tb_masked_byte_pattern_scan_core: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/mbps_pkg.sv
rtl/mbps_window.sv
rtl/mbps_outq.sv
rtl/masked_byte_pattern_scan_core.sv
rtl/mbps_checker.sv
bench/tb_masked_byte_pattern_scan_core.sv
